// ===== design/lbp_pkg.sv =====
// Shared types, codes and constants for the level-band pump PWM controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package lbp_pkg;

  // Field widths
  localparam int unsigned ADC_W   = 12;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Item codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'b1;

  // Duty codes
  localparam logic [DUTY_W-1:0] DUTY_OFF   = 7'd0;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd10;
  localparam logic [DUTY_W-1:0] DUTY_LOW   = 7'd26;
  localparam logic [DUTY_W-1:0] DUTY_MID   = 7'd43;
  localparam logic [DUTY_W-1:0] DUTY_FULL  = 7'd100;

  // Reset values
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 8'd50;
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 8'd150;

  localparam int unsigned PWM_PERIOD_DEF = 100;

  // level = floor(adc * 1023 / 20475) = floor(adc * 341 / 6825),
  // done as floor(adc * 341 * ceil(2^36 / 6825) / 2^36); exact over 12-bit adc.
  localparam longint unsigned LevelNum   = 64'd341;
  localparam longint unsigned LevelDen   = 64'd6825;
  localparam int unsigned     LEVEL_SHIFT = 36;
  localparam longint unsigned LevelRecip =
    ((64'd1 << LEVEL_SHIFT) + LevelDen - 64'd1) / LevelDen;
  localparam logic [31:0]     LEVEL_MULT = 32'(LevelNum * LevelRecip);
  localparam int unsigned     LEVEL_PROD_W = ADC_W + 32;

  // Reverse-zone thresholds in thousandths of a level unit
  localparam int unsigned REV_W = 18;
  localparam logic [REV_W-1:0] REV_P70_SCALE  = 18'd300;
  localparam logic [REV_W-1:0] REV_P70_OFFSET = 18'd143290;
  localparam logic [REV_W-1:0] REV_P90_SCALE  = 18'd100;
  localparam logic [REV_W-1:0] REV_P90_OFFSET = 18'd184230;
  localparam logic [REV_W-1:0] LEVEL_MILLI    = 18'd1000;

  typedef struct packed {
    logic             cmd;
    logic [ADC_W-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic               pwm_drive;
    logic               pump_reverse;
    logic [DUTY_W-1:0]  duty_percent;
    logic [LEVEL_W-1:0] level_value;
  } out_item_t;

  // Zone decision for one level
  typedef struct packed {
    logic              set_dir;
    logic              reverse;
    logic [DUTY_W-1:0] duty;
  } zone_t;

endpackage

`default_nettype wire

// ===== design/level_band_pump_pwm_controller.sv =====
// Top level of the level-band pump PWM controller: registers, handshakes, state.
// Depends on lbp_pkg, lbp_level_scale, lbp_zone_decode and lbp_pwm_step.
`default_nettype none

// Channel  Direction  Handshake               Word
// -------  ---------  ----------------------  ---------------------------------
// in       sink       in_valid_i / in_ready_o  in_item_t  (cmd, adc_sample)
// out      source     out_valid_o/out_ready_i  out_item_t (pin, dir, duty, level)
// cfg      sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One word is taken per cycle while the input side is not stalled. A word sits
// in the input register, then its result is loaded into the output register.
// Reset loads duty 10, phase 0, pin high, direction reverse, level 0 and the
// limits 50 and 150. A stalled output holds the input register, which still
// takes one more word; the input side stalls only when both are full.
// Configuration is always ready and takes effect in the next cycle.

module level_band_pump_pwm_controller
  import lbp_pkg::*;
#(
  parameter int unsigned PWM_PERIOD = PWM_PERIOD_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_item_i,

  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o,

  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LIMIT_W-1:0]   cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(PWM_PERIOD);

  // Input register
  logic     s1_valid_q;
  in_item_t s1_item_q;

  // Output register
  logic      out_valid_q;
  out_item_t out_item_q;

  // Controller state
  logic [LIMIT_W-1:0] low_q,   low_d;
  logic [LIMIT_W-1:0] high_q,  high_d;
  logic [DUTY_W-1:0]  duty_q,  duty_d;
  logic [CNT_W-1:0]   cnt_q,   cnt_d;
  logic               pwm_q,   pwm_d;
  logic               dir_q,   dir_d;
  logic [LEVEL_W-1:0] level_q, level_d;

  logic               out_space;
  logic               s1_fire;
  logic               in_fire;
  logic [LEVEL_W-1:0] level_new;
  zone_t              zone;
  logic [CNT_W-1:0]   cnt_tick;
  logic               pin_tick;

  assign out_space   = !out_valid_q || out_ready_i;
  assign s1_fire     = s1_valid_q && out_space;
  assign in_ready_o  = !s1_valid_q || out_space;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  lbp_level_scale u_scale (
    .adc_i   (s1_item_q.adc_sample),
    .level_o (level_new)
  );

  lbp_zone_decode u_zone (
    .level_i      (level_new),
    .low_limit_i  (low_q),
    .high_limit_i (high_q),
    .zone_o       (zone)
  );

  lbp_pwm_step #(
    .PWM_PERIOD (PWM_PERIOD),
    .CNT_W      (CNT_W)
  ) u_pwm (
    .duty_i (duty_q),
    .cnt_i  (cnt_q),
    .pin_i  (pwm_q),
    .cnt_o  (cnt_tick),
    .pin_o  (pin_tick)
  );

  // Next state: a sample moves level, duty and direction; a tick moves the PWM
  always_comb begin
    duty_d  = duty_q;
    cnt_d   = cnt_q;
    pwm_d   = pwm_q;
    dir_d   = dir_q;
    level_d = level_q;
    if (s1_fire) begin
      unique case (s1_item_q.cmd)
        CMD_SAMPLE: begin
          level_d = level_new;
          duty_d  = zone.duty;
          if (zone.set_dir) begin
            dir_d = zone.reverse;
          end
        end
        CMD_TICK: begin
          cnt_d = cnt_tick;
          pwm_d = pin_tick;
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration writes; an unknown index is dropped
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LOW_LIMIT:  low_d  = cfg_data_i;
        REG_HIGH_LIMIT: high_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      low_q       <= LOW_LIMIT_RST;
      high_q      <= HIGH_LIMIT_RST;
      duty_q      <= DUTY_RESET;
      cnt_q       <= '0;
      pwm_q       <= 1'b1;
      dir_q       <= 1'b1;
      level_q     <= '0;
    end else begin
      // Hold the input register while the output is stalled
      if (in_ready_o) begin
        s1_valid_q <= in_fire;
      end
      if (out_space) begin
        out_valid_q <= s1_valid_q;
      end
      low_q   <= low_d;
      high_q  <= high_d;
      duty_q  <= duty_d;
      cnt_q   <= cnt_d;
      pwm_q   <= pwm_d;
      dir_q   <= dir_d;
      level_q <= level_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
    if (s1_fire) begin
      out_item_q.pwm_drive    <= pwm_d;
      out_item_q.pump_reverse <= dir_d;
      out_item_q.duty_percent <= duty_d;
      out_item_q.level_value  <= level_d;
    end
  end

  // A word held in the input register stays put while the output stalls
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_space) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input register lost or changed a stalled word");

  // Every word leaving the input register lands in the output register
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("result of a word was not loaded");

  // Duty only ever takes one of its defined codes
  a_duty_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_q == DUTY_OFF) || (duty_q == DUTY_RESET) || (duty_q == DUTY_LOW) ||
    (duty_q == DUTY_MID) || (duty_q == DUTY_FULL))
    else $error("duty register holds an undefined code");

  // A tick at full duty drives the pin low and leaves the phase alone
  a_full_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_item_q.cmd == CMD_TICK) && (duty_q == DUTY_FULL))
      |=> (!pwm_q && $stable(cnt_q)))
    else $error("full-duty tick did not hold the pin low");

  // The phase counter never reaches the period
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W+1)'(cnt_q) < (CNT_W+1)'(PWM_PERIOD)))
    else $error("phase counter out of range");

endmodule

`default_nettype wire

// ===== design/lbp_level_scale.sv =====
// Scales a 12-bit ADC word to level units by reciprocal multiplication.
// Depends on lbp_pkg.
`default_nettype none

module lbp_level_scale
  import lbp_pkg::*;
(
  input  wire logic [ADC_W-1:0]   adc_i,
  output logic      [LEVEL_W-1:0] level_o
);

  logic [LEVEL_PROD_W-1:0] prod;

  assign prod    = LEVEL_PROD_W'(adc_i) * LEVEL_PROD_W'(LEVEL_MULT);
  assign level_o = prod[LEVEL_SHIFT +: LEVEL_W];

endmodule

`default_nettype wire

// ===== design/lbp_zone_decode.sv =====
// Picks pump direction and duty from a level and the two limits.
// Depends on lbp_pkg.
`default_nettype none

module lbp_zone_decode
  import lbp_pkg::*;
(
  input  wire logic [LEVEL_W-1:0] level_i,
  input  wire logic [LIMIT_W-1:0] low_limit_i,
  input  wire logic [LIMIT_W-1:0] high_limit_i,
  output zone_t                   zone_o
);

  localparam int unsigned FWD_W = LEVEL_W + 4;

  logic [FWD_W-1:0] level_x10;
  logic [FWD_W-1:0] low_x1;
  logic [FWD_W-1:0] low_x3;
  logic [REV_W-1:0] level_milli;
  logic [REV_W-1:0] rev_p70;
  logic [REV_W-1:0] rev_p90;

  assign level_x10   = FWD_W'(level_i) * FWD_W'(10);
  assign low_x1      = FWD_W'(low_limit_i);
  assign low_x3      = FWD_W'(low_limit_i) * FWD_W'(3);
  assign level_milli = REV_W'(level_i) * LEVEL_MILLI;
  assign rev_p70     = REV_W'(high_limit_i) * REV_P70_SCALE + REV_P70_OFFSET;
  assign rev_p90     = REV_W'(high_limit_i) * REV_P90_SCALE + REV_P90_OFFSET;

  // Forward test wins when the limits are crossed
  always_comb begin
    zone_o = '{set_dir: 1'b0, reverse: 1'b0, duty: DUTY_OFF};
    priority if (level_i < low_limit_i) begin
      zone_o.set_dir = 1'b1;
      zone_o.reverse = 1'b0;
      priority if (level_x10 < low_x1) zone_o.duty = DUTY_FULL;
      else if (level_x10 < low_x3)     zone_o.duty = DUTY_MID;
      else                             zone_o.duty = DUTY_LOW;
    end else if (level_i > high_limit_i) begin
      zone_o.set_dir = 1'b1;
      zone_o.reverse = 1'b1;
      priority if (level_milli < rev_p70) zone_o.duty = DUTY_LOW;
      else if (level_milli < rev_p90)     zone_o.duty = DUTY_MID;
      else                                zone_o.duty = DUTY_FULL;
    end else begin
      zone_o.duty = DUTY_OFF;
    end
  end

endmodule

`default_nettype wire

// ===== design/lbp_pwm_step.sv =====
// Next phase count and pin level of the active-low PWM for one tick.
// Depends on lbp_pkg.
`default_nettype none

module lbp_pwm_step
  import lbp_pkg::*;
#(
  parameter int unsigned PWM_PERIOD = PWM_PERIOD_DEF,
  parameter int unsigned CNT_W      = $clog2(PWM_PERIOD)
) (
  input  wire logic [DUTY_W-1:0] duty_i,
  input  wire logic [CNT_W-1:0]  cnt_i,
  input  wire logic              pin_i,
  output logic      [CNT_W-1:0]  cnt_o,
  output logic                   pin_o
);

  localparam int unsigned CMP_W = ((CNT_W > DUTY_W) ? CNT_W : DUTY_W) + 1;

  logic [CNT_W:0]     cnt_inc;
  logic [CNT_W-1:0]   cnt_wrap;
  logic [CMP_W-1:0]   cnt_cmp;
  logic [CMP_W-1:0]   duty_end;

  assign cnt_inc  = {1'b0, cnt_i} + (CNT_W+1)'(1);
  assign cnt_wrap = (cnt_inc >= (CNT_W+1)'(PWM_PERIOD)) ? '0 : cnt_inc[CNT_W-1:0];
  assign cnt_cmp  = CMP_W'(cnt_wrap);
  assign duty_end = CMP_W'(duty_i) + CMP_W'(1);

  // Fully off and fully on hold the counter
  always_comb begin
    cnt_o = cnt_i;
    pin_o = pin_i;
    priority if (duty_i == DUTY_OFF) begin
      pin_o = 1'b1;
    end else if (duty_i == DUTY_FULL) begin
      pin_o = 1'b0;
    end else begin
      cnt_o = cnt_wrap;
      priority if (cnt_cmp == CMP_W'(1)) pin_o = 1'b0;
      else if (cnt_cmp == duty_end)      pin_o = 1'b1;
      else                               pin_o = pin_i;
    end
  end

endmodule

`default_nettype wire
